// ===== design/rse_pkg.sv =====
// Shared constants and interface types for the range split enumerator.
`default_nettype none
package rse_pkg;

  localparam int AREAS = 8;
  localparam int SET_W = 8;
  localparam int DEPTH = 1 << SET_W;
  localparam int IDX_W = (AREAS > 1) ? $clog2(AREAS) : 1;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'((1 << AREAS) - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AREAS - 1);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] addr_a;
    logic [SET_W-1:0] addr_b;
  } rd_req_t;

  typedef struct packed {
    logic bit_a;
    logic bit_b;
  } rd_rsp_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] addr;
    logic             data;
  } wr_req_t;

endpackage
`default_nettype wire

// ===== design/rse_perm_mem.sv =====
// Permission store: 256 x 1 memory, two registered read ports, one write port.
`default_nettype none
module rse_perm_mem (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rse_pkg::rd_req_t rd,
  input  wire rse_pkg::wr_req_t wr,
  output rse_pkg::rd_rsp_t     rsp
);

  logic                      mem [rse_pkg::DEPTH];
  logic [rse_pkg::DEPTH-1:0] vld;
  logic                      data_a;
  logic                      data_b;
  logic                      vld_a;
  logic                      vld_b;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      data_a <= mem[rd.addr_a];
      data_b <= mem[rd.addr_b];
    end
  end

  // unwritten entries read as one
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_a <= vld[rd.addr_a];
        vld_b <= vld[rd.addr_b];
      end
    end
  end

  assign rsp.bit_a = vld_a ? data_a : 1'b1;
  assign rsp.bit_b = vld_b ? data_b : 1'b1;

endmodule
`default_nettype wire

// ===== design/range_split_enumerator_core.sv =====
// Range split enumerator: permission store plus sequential split walker.
// Load beat: written on accept, no result; the next beat may follow at once.
// Query beat: one item at a time; per area a read state, and for an occupied
// area one emit step per emitted split while the output is free (up to 32
// results); each result waits in the one-result hold register that finds the
// last beat. Reset: the permission store reads as all ones at once through
// per-entry valid bits; no clearing pass.
`default_nettype none
module range_split_enumerator_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      func,
  input  wire logic [rse_pkg::SET_W-1:0] area_set,
  input  wire logic                      permit,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [rse_pkg::SET_W-1:0]      left_range,
  output logic [rse_pkg::SET_W-1:0]      right_range,
  output logic                           last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;

  logic [2:0]                  state;
  logic [rse_pkg::SET_W-1:0]   rng;
  logic [rse_pkg::IDX_W-1:0]   idx;
  logic [1:0]                  sub;
  logic                        pend_valid;
  logic [rse_pkg::SET_W-1:0]   pend_left;
  logic [rse_pkg::SET_W-1:0]   pend_right;

  rse_pkg::rd_req_t            rd;
  rse_pkg::rd_rsp_t            rsp;
  rse_pkg::wr_req_t            wr;

  logic [rse_pkg::SET_W-1:0]   in_rng;
  logic [rse_pkg::SET_W-1:0]   one;
  logic [rse_pkg::SET_W-1:0]   rest;
  logic                        rest_multi;
  logic                        in_single;
  logic                        accept;
  logic                        out_free;
  logic                        can_put;
  logic                        area_done;
  logic [rse_pkg::SET_W-1:0]   new_left;
  logic [rse_pkg::SET_W-1:0]   new_right;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign in_rng     = area_set & rse_pkg::SET_MASK;
  assign in_single  = (in_rng != '0) && ((in_rng & (in_rng - 1'b1)) == '0);
  assign one        = rse_pkg::SET_W'(1) << idx;
  assign rest       = rng ^ one;
  assign rest_multi = (rest & (rest - 1'b1)) != '0;
  assign out_free   = !out_valid || !out_stall;
  assign can_put    = !pend_valid || out_free;

  assign wr.en   = accept && (func == rse_pkg::FUNC_LOAD);
  assign wr.addr = in_rng;
  assign wr.data = permit;

  assign rd.en     = (state == S_READ) && rng[idx];
  assign rd.addr_a = one;
  assign rd.addr_b = rest;

  rse_perm_mem u_mem (
    .clk (clk),
    .rst (rst),
    .rd  (rd),
    .wr  (wr),
    .rsp (rsp)
  );

  always_comb begin
    case (sub)
      2'd0: begin
        new_left  = one;
        new_right = rng;
      end
      2'd1: begin
        new_left  = rng;
        new_right = one;
      end
      2'd2: begin
        new_left  = one;
        new_right = rest;
      end
      default: begin
        new_left  = rest;
        new_right = one;
      end
    endcase
  end

  always_comb begin
    case (sub)
      2'd0:    area_done = 1'b0;
      2'd1:    area_done = !rsp.bit_b;
      2'd2:    area_done = !rest_multi;
      default: area_done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      sub        <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (func == rse_pkg::FUNC_QUERY)) begin
            rng <= in_rng;
            idx <= '0;
            sub <= '0;
            if (in_single) begin
              pend_left  <= in_rng;
              pend_right <= in_rng;
              pend_valid <= 1'b1;
              state      <= S_FLUSH;
            end else if (in_rng == '0) begin
              state <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (rng[idx]) begin
            state <= S_EMIT;
          end else if (idx == rse_pkg::LAST_IDX) begin
            state <= S_FLUSH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          if (!rsp.bit_a || (can_put && area_done)) begin
            sub <= '0;
            if (idx == rse_pkg::LAST_IDX) begin
              state <= S_FLUSH;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end else if (can_put) begin
            sub <= sub + 1'b1;
          end
          if (rsp.bit_a && can_put) begin
            if (pend_valid) begin
              left_range  <= pend_left;
              right_range <= pend_right;
              last        <= 1'b0;
              out_valid   <= 1'b1;
            end
            pend_left  <= new_left;
            pend_right <= new_right;
            pend_valid <= 1'b1;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            left_range  <= pend_left;
            right_range <= pend_right;
            last        <= 1'b1;
            out_valid   <= 1'b1;
            pend_valid  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state != S_IDLE))
    else $error("held split while idle");

  a_one_side_single: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (($countones(left_range) == 1) || ($countones(right_range) == 1)))
    else $error("split with no singleton side");

  a_emit_occupied: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> rng[idx])
    else $error("walking an unoccupied area");

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((left_range != '0) && (right_range != '0)))
    else $error("empty range in split");

endmodule
`default_nettype wire

// ===== test/range_split_enumerator_core_check.sv =====
// Checker for the range split enumerator: tracks the permission store and compares splits.
module range_split_enumerator_core_check (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic                      func,
  input  wire logic [rse_pkg::SET_W-1:0] area_set,
  input  wire logic                      permit,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic [rse_pkg::SET_W-1:0] left_range,
  input  wire logic [rse_pkg::SET_W-1:0] right_range,
  input  wire logic                      last,
  output int                             errors,
  output int                             pending
);

  typedef struct packed {
    logic [rse_pkg::SET_W-1:0] left_set;
    logic [rse_pkg::SET_W-1:0] right_set;
    logic                      fin;
  } split_t;

  split_t splits_due[$];
  bit     allowed[rse_pkg::DEPTH];

  task automatic queue_split(logic [rse_pkg::SET_W-1:0] l, logic [rse_pkg::SET_W-1:0] r);
    split_t item;
    item.left_set  = l;
    item.right_set = r;
    item.fin       = 1'b0;
    splits_due.insert(splits_due.size(), item);
  endtask

  task automatic take_beat(logic f, logic [rse_pkg::SET_W-1:0] raw, logic p);
    logic [rse_pkg::SET_W-1:0] span;
    logic [rse_pkg::SET_W-1:0] one;
    logic [rse_pkg::SET_W-1:0] rest;
    int                        base;
    span = raw & rse_pkg::SET_MASK;
    if (f == rse_pkg::FUNC_LOAD) begin
      allowed[span] = p;
      return;
    end
    base = splits_due.size();
    if ($countones(span) == 1) begin
      queue_split(span, span);
    end else begin
      for (int i = 0; i < rse_pkg::AREAS; i++) begin
        one = rse_pkg::SET_W'(1) << i;
        if (span[i] && allowed[one]) begin
          queue_split(one, span);
          queue_split(span, one);
          rest = span ^ one;
          if (allowed[rest]) begin
            queue_split(one, rest);
            if ($countones(rest) > 1) queue_split(rest, one);
          end
        end
      end
    end
    if (splits_due.size() > base) begin
      splits_due[splits_due.size() - 1].fin = 1'b1;
    end
  endtask

  function automatic void check_field(string tag, logic [rse_pkg::SET_W-1:0] want,
                                      logic [rse_pkg::SET_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    split_t want;
    if (rst) begin
      splits_due.delete();
      foreach (allowed[a]) allowed[a] = 1'b1;
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (splits_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got left %h right %h last %b",
                   $time, left_range, right_range, last);
          errors++;
        end else begin
          want = splits_due.pop_front();
          check_field("left_range", want.left_set, left_range);
          check_field("right_range", want.right_set, right_range);
          check_field("last", rse_pkg::SET_W'(want.fin), rse_pkg::SET_W'(last));
        end
      end
      if (in_valid && !in_stall) take_beat(func, area_set, permit);
    end
    pending = splits_due.size();
  end

endmodule

// ===== test/range_split_enumerator_core_test.sv =====
// Testbench top for the range split enumerator: stimulus, pacing and verdict.
module range_split_enumerator_core_test;

  localparam int LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 470;
  localparam int TAIL = 64;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      func = 1'b0;
  logic [rse_pkg::SET_W-1:0] area_set = '0;
  logic                      permit = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [rse_pkg::SET_W-1:0] left_range;
  logic [rse_pkg::SET_W-1:0] right_range;
  logic                      last;
  int                        errors;
  int                        pending;
  int                        cycles = 0;
  bit                        quiet = 1'b0;

  range_split_enumerator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .area_set(area_set), .permit(permit),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_range(left_range), .right_range(right_range), .last(last)
  );

  range_split_enumerator_core_check chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .area_set(area_set), .permit(permit),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_range(left_range), .right_range(right_range), .last(last),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [rse_pkg::SET_W-1:0] pick_set(int n);
    logic [rse_pkg::SET_W-1:0] s;
    s = '0;
    while ($countones(s) < n) s[$urandom_range(0, rse_pkg::SET_W - 1)] = 1'b1;
    return s;
  endfunction

  // receiver pacing
  initial begin : sink
    int hold;
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  task automatic send_beat(logic f, logic [rse_pkg::SET_W-1:0] s, logic p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    area_set <= s;
    permit   <= p;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stim
    logic [rse_pkg::SET_W-1:0] s;
    logic [rse_pkg::SET_W-1:0] last_load;
    int                        r;
    last_load = 8'h0F;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(rse_pkg::FUNC_QUERY, 8'h00, 1'b1);
    send_beat(rse_pkg::FUNC_QUERY, 8'h01, 1'b0);
    send_beat(rse_pkg::FUNC_QUERY, 8'h80, 1'b1);
    send_beat(rse_pkg::FUNC_QUERY, 8'hFF, 1'b0);
    send_beat(rse_pkg::FUNC_QUERY, 8'h03, 1'b1);
    send_beat(rse_pkg::FUNC_LOAD,  8'h04, 1'b0);
    send_beat(rse_pkg::FUNC_LOAD,  8'hFB, 1'b0);
    send_beat(rse_pkg::FUNC_QUERY, 8'hFF, 1'b1);
    send_beat(rse_pkg::FUNC_LOAD,  8'h0E, 1'b0);
    send_beat(rse_pkg::FUNC_QUERY, 8'h0F, 1'b0);
    send_beat(rse_pkg::FUNC_QUERY, 8'h04, 1'b1);
    send_beat(rse_pkg::FUNC_LOAD,  8'h00, 1'b0);
    send_beat(rse_pkg::FUNC_LOAD,  8'h01, 1'b0);
    send_beat(rse_pkg::FUNC_LOAD,  8'h02, 1'b0);
    send_beat(rse_pkg::FUNC_QUERY, 8'h03, 1'b0);
    send_beat(rse_pkg::FUNC_QUERY, 8'h06, 1'b1);
    send_beat(rse_pkg::FUNC_LOAD,  8'h01, 1'b1);
    send_beat(rse_pkg::FUNC_LOAD,  8'h02, 1'b1);
    send_beat(rse_pkg::FUNC_LOAD,  8'h04, 1'b1);
    send_beat(rse_pkg::FUNC_LOAD,  8'hFB, 1'b1);
    send_beat(rse_pkg::FUNC_LOAD,  8'h0E, 1'b1);
    send_beat(rse_pkg::FUNC_QUERY, 8'hAA, 1'b0);
    send_beat(rse_pkg::FUNC_QUERY, 8'h55, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n / 60) % 3) == 2;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // load: singletons and the rests of recent queries matter most
        if ($urandom_range(0, 1)) begin
          s = rse_pkg::SET_W'(1) << $urandom_range(0, rse_pkg::AREAS - 1);
        end else begin
          s = pick_set($urandom_range(0, rse_pkg::SET_W));
        end
        last_load = s;
        send_beat(rse_pkg::FUNC_LOAD, s, $urandom_range(0, 99) < 70);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) s = last_load | (rse_pkg::SET_W'(1) << $urandom_range(0, rse_pkg::AREAS - 1));
        else if (r < 30) s = '0;
        else if (r < 40) s = rse_pkg::SET_W'($urandom_range(0, 255));
        else s = pick_set($urandom_range(1, 5));
        send_beat(rse_pkg::FUNC_QUERY, s, 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
